>>> hw/rtl/pcxrle_pkg.sv
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Shared constants and types for the PCX 8bpp run-length pixel decoder.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

	localparam int MAX_WIDTH  = 640;
	localparam int MAX_HEIGHT = 480;

	localparam int BYTE_W  = 8;
	localparam int COL_W   = 10;
	localparam int ROW_W   = 9;
	localparam int COUNT_W = 6;
	localparam int IDX_W   = 2;
	localparam int CFG_W   = 10;
	localparam int PIX_W   = BYTE_W + COL_W + ROW_W;
	localparam int TDATA_W = ((PIX_W + 7) / 8) * 8;

	localparam logic [BYTE_W-1:0] RUN_MARK   = 8'hC0;
	localparam logic [BYTE_W-1:0] COUNT_MASK = 8'h3F;

	localparam logic [COL_W-1:0] LAST_COL_MAX   = COL_W'(MAX_WIDTH - 1);
	localparam logic [ROW_W-1:0] LAST_ROW_MAX   = ROW_W'(MAX_HEIGHT - 1);
	localparam logic [COL_W-1:0] LAST_COL_RESET = COL_W'(319);
	localparam logic [ROW_W-1:0] LAST_ROW_RESET = ROW_W'(199);

	localparam logic [IDX_W-1:0] REG_LAST_COLUMN = 2'd0;
	localparam logic [IDX_W-1:0] REG_LAST_ROW    = 2'd1;

	typedef struct packed {
		logic emit;
		logic use_input;
		logic literal;
		logic load_count;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic is_prefix;
		logic count_zero;
		logic run_last;
	} dp_stat_t;

endpackage

>>> hw/rtl/pcxrle_ctrl.sv
// ----------------------------------------------------------------------------
// pcxrle_ctrl
// Byte sequencing: code byte, run value byte, run emission.
// ----------------------------------------------------------------------------
module pcxrle_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic                  cfg_we,
	input  logic [pcxrle_pkg::IDX_W-1:0] cfg_index,
	input  pcxrle_pkg::dp_stat_t  stat,
	output pcxrle_pkg::ctrl_cmd_t cmd
);

	localparam logic [1:0] ST_CODE  = 2'd0;
	localparam logic [1:0] ST_VALUE = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       accept;
	logic       cfg_restart;

	assign s_axis_tready = ((state_q == ST_CODE) || (state_q == ST_VALUE)) && stat.out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_restart   = cfg_we && ((cfg_index == pcxrle_pkg::REG_LAST_COLUMN) ||
		(cfg_index == pcxrle_pkg::REG_LAST_ROW));

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_CODE: begin
				if (accept) begin
					if (stat.is_prefix) begin
						cmd.load_count = 1'b1;
						state_nxt      = ST_VALUE;
					end else begin
						cmd.emit      = 1'b1;
						cmd.use_input = 1'b1;
						cmd.literal   = 1'b1;
					end
				end
			end
			ST_VALUE: begin
				if (accept) begin
					if (stat.count_zero) begin
						state_nxt = ST_CODE;
					end else begin
						cmd.emit      = 1'b1;
						cmd.use_input = 1'b1;
						state_nxt     = stat.run_last ? ST_CODE : ST_RUN;
					end
				end
			end
			ST_RUN: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.run_last) begin
						state_nxt = ST_CODE;
					end
				end
			end
			default: begin
				state_nxt = ST_CODE;
			end
		endcase
		if (cfg_restart) begin
			state_nxt = ST_CODE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CODE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> hw/rtl/pcxrle_dp.sv
// ----------------------------------------------------------------------------
// pcxrle_dp
// Geometry registers, position counters, run counter and output register.
// ----------------------------------------------------------------------------
module pcxrle_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [pcxrle_pkg::BYTE_W-1:0]          in_byte,
	input  logic                                   cfg_we,
	input  logic [pcxrle_pkg::IDX_W-1:0]           cfg_index,
	input  logic [pcxrle_pkg::CFG_W-1:0]           cfg_data,
	input  pcxrle_pkg::ctrl_cmd_t                  cmd,
	output pcxrle_pkg::dp_stat_t                   stat,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [pcxrle_pkg::BYTE_W-1:0]          pixel_value,
	output logic [pcxrle_pkg::COL_W-1:0]           pixel_column,
	output logic [pcxrle_pkg::ROW_W-1:0]           pixel_row,
	output logic                                   run_last,
	output logic                                   image_done
);

	logic [pcxrle_pkg::COL_W-1:0]   last_col_q;
	logic [pcxrle_pkg::ROW_W-1:0]   last_row_q;
	logic [pcxrle_pkg::COL_W-1:0]   col_q;
	logic [pcxrle_pkg::ROW_W-1:0]   row_q;
	logic [pcxrle_pkg::COUNT_W-1:0] count_q;
	logic [pcxrle_pkg::BYTE_W-1:0]  value_q;
	logic                           valid_q;
	logic [pcxrle_pkg::BYTE_W-1:0]  value_q_out;
	logic [pcxrle_pkg::COL_W-1:0]   col_out_q;
	logic [pcxrle_pkg::ROW_W-1:0]   row_out_q;
	logic                           last_out_q;
	logic                           done_out_q;

	logic [pcxrle_pkg::BYTE_W-1:0]  sel_value;
	logic [pcxrle_pkg::BYTE_W-1:0]  count_byte;
	logic [pcxrle_pkg::COL_W-1:0]   cfg_col;
	logic [pcxrle_pkg::ROW_W-1:0]   cfg_row;
	logic                           row_end;
	logic                           img_end;
	logic                           run_end;
	logic                           last_now;

	assign sel_value  = cmd.use_input ? in_byte : value_q;
	assign count_byte = in_byte & pcxrle_pkg::COUNT_MASK;
	assign row_end    = col_q >= last_col_q;
	assign img_end    = row_end && (row_q >= last_row_q);
	assign run_end    = (count_q == pcxrle_pkg::COUNT_W'(1)) || row_end;
	assign last_now   = cmd.literal || run_end;

	assign cfg_col = (cfg_data > pcxrle_pkg::LAST_COL_MAX) ? pcxrle_pkg::LAST_COL_MAX : cfg_data;
	assign cfg_row = (cfg_data[pcxrle_pkg::ROW_W-1:0] > pcxrle_pkg::LAST_ROW_MAX) ?
		pcxrle_pkg::LAST_ROW_MAX : cfg_data[pcxrle_pkg::ROW_W-1:0];

	assign stat.out_free   = !valid_q || out_ready;
	assign stat.is_prefix  = (in_byte & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK;
	assign stat.count_zero = count_q == '0;
	assign stat.run_last   = run_end;

	// geometry and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= pcxrle_pkg::LAST_COL_RESET;
			last_row_q <= pcxrle_pkg::LAST_ROW_RESET;
			col_q      <= '0;
			row_q      <= '0;
			count_q    <= '0;
		end else if (cfg_we) begin
			if (cfg_index == pcxrle_pkg::REG_LAST_COLUMN) begin
				last_col_q <= cfg_col;
				col_q      <= '0;
				row_q      <= '0;
				count_q    <= '0;
			end else if (cfg_index == pcxrle_pkg::REG_LAST_ROW) begin
				last_row_q <= cfg_row;
				col_q      <= '0;
				row_q      <= '0;
				count_q    <= '0;
			end
		end else begin
			if (cmd.load_count) begin
				count_q <= count_byte[pcxrle_pkg::COUNT_W-1:0];
			end else if (cmd.emit && !cmd.literal) begin
				count_q <= count_q - pcxrle_pkg::COUNT_W'(1);
			end
			if (cmd.emit) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= img_end ? '0 : row_q + pcxrle_pkg::ROW_W'(1);
				end else begin
					col_q <= col_q + pcxrle_pkg::COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			value_q     <= sel_value;
			value_q_out <= sel_value;
			col_out_q   <= col_q;
			row_out_q   <= row_q;
			last_out_q  <= last_now;
			done_out_q  <= img_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid    = valid_q;
	assign pixel_value  = value_q_out;
	assign pixel_column = col_out_q;
	assign pixel_row    = row_out_q;
	assign run_last     = last_out_q;
	assign image_done   = done_out_q;

endmodule

>>> hw/rtl/pcx_rle_pixel_decoder_unit.sv
// ----------------------------------------------------------------------------
// pcx_rle_pixel_decoder_unit
// PCX 8bpp run-length decoder: compressed bytes in, positioned pixels out.
// ----------------------------------------------------------------------------
// channel   dir  beat                  tdata / tuser
// s_axis    in   one compressed byte   [7:0] code_byte
// m_axis    out  one decoded pixel     [7:0] value [17:8] column [26:18] row;
//                                      tlast run_last, tuser image_done
// cfg       in   one register write    index 0 last_column, 1 last_row
//
// Literal byte: one pixel, one byte per cycle. Run: prefix byte, then value
// byte, then one pixel per cycle from the run counter; input
// is held until the run ends or hits the row end. A write to last_column
// or last_row restarts the image at (0,0). Output stalls hold the whole pipe.
// ----------------------------------------------------------------------------
module pcx_rle_pixel_decoder_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [pcxrle_pkg::BYTE_W-1:0]       s_axis_tdata,  // [7:0] code_byte
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [pcxrle_pkg::TDATA_W-1:0]      m_axis_tdata,  // value, column, row, pad
	output logic                                m_axis_tlast,
	output logic                                m_axis_tuser,  // image_done
	input  logic                                cfg_we,
	input  logic [pcxrle_pkg::IDX_W-1:0]        cfg_index,
	input  logic [pcxrle_pkg::CFG_W-1:0]        cfg_data
);

	pcxrle_pkg::ctrl_cmd_t            cmd;
	pcxrle_pkg::dp_stat_t             stat;
	logic [pcxrle_pkg::BYTE_W-1:0]    pixel_value;
	logic [pcxrle_pkg::COL_W-1:0]     pixel_column;
	logic [pcxrle_pkg::ROW_W-1:0]     pixel_row;

	pcxrle_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.stat          (stat),
		.cmd           (cmd)
	);

	pcxrle_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_byte      (s_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.pixel_value  (pixel_value),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.run_last     (m_axis_tlast),
		.image_done   (m_axis_tuser)
	);

	assign m_axis_tdata = {
		{(pcxrle_pkg::TDATA_W - pcxrle_pkg::PIX_W){1'b0}},
		pixel_row, pixel_column, pixel_value
	};

endmodule

>>> hw/rtl/pcxrle_chk.sv
// ----------------------------------------------------------------------------
// pcxrle_chk
// Port-level checks for the PCX run-length decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pcxrle_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [pcxrle_pkg::TDATA_W-1:0]      m_axis_tdata,
	input logic                                m_axis_tlast,
	input logic                                m_axis_tuser
);

	// stalled beat keeps valid and tdata stable
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed under stall");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("image end without run end");

	// a run keeps going without gaps
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("gap inside a run");

	a_run_hold_in: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input taken during a run");

endmodule

bind pcx_rle_pixel_decoder_unit pcxrle_chk u_pcxrle_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
